// ----- src/prsu_pkg.sv -----
// Shared types, constants and helpers for the packed raw sample unpacker.
`default_nettype none

package prsu_pkg;

   // Field and datapath widths
   localparam int BYTE_BITS      = 8;
   localparam int PAIR_BITS      = 16;
   localparam int ACC_BITS       = 24;
   localparam int MAX_RESULTS    = 8;
   localparam int BITS_WIDTH     = 5;
   localparam int HELD_WIDTH     = 5;
   localparam int RES_CNT_WIDTH  = 4;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH = 28;
   localparam int CSR_IDX_WIDTH  = 1;

   // Default counter width for samples per strip
   localparam int COUNT_WIDTH_DEFAULT = 28;

   // Job queue depth between front and back
   localparam int FIFO_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SAMPLE_BITS       = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SAMPLES_PER_STRIP = 1'd1;

   // Reset value of sample_bits
   localparam logic [BITS_WIDTH-1:0] SAMPLE_BITS_RESET = 5'd16;

   // Strip end status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_CONTINUE = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SHORT    = 2'd2;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 strip_end;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    has_sample;
      logic                    last_of_run;
      logic [STATUS_WIDTH-1:0] end_status;
   } rsp_payload_type;

   typedef struct packed {
      logic                      we;
      logic [CSR_IDX_WIDTH-1:0]  index;
      logic [CSR_DATA_WIDTH-1:0] wdata;
   } csr_write_type;

   // One classified byte: bits to slice and how many samples to take
   typedef struct packed {
      logic [ACC_BITS-1:0]      acc;
      logic [HELD_WIDTH-1:0]    pos;
      logic [BITS_WIDTH-1:0]    bits;
      logic [RES_CNT_WIDTH-1:0] count;
      logic                     strip_end;
      logic [STATUS_WIDTH-1:0]  status;
   } job_type;

   // Low-order mask of the given sample width (1..16)
   function automatic logic [SAMPLE_WIDTH-1:0] sample_mask(input logic [BITS_WIDTH-1:0] bits);
      logic [SAMPLE_WIDTH:0] m;
      m = ((SAMPLE_WIDTH+1)'(1) << bits) - (SAMPLE_WIDTH+1)'(1);
      return m[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/prsu_front.sv -----
// Front end: config registers, strip state and per-byte sample classification.
`default_nettype none

module prsu_front #(
   parameter int COUNT_WIDTH = prsu_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  prsu_pkg::csr_write_type   csr,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  prsu_pkg::req_payload_type req_payload,
   input  wire                       fifo_full,
   output logic                      push,
   output prsu_pkg::job_type         job
);

   localparam int HW = prsu_pkg::HELD_WIDTH;
   localparam int BW = prsu_pkg::BITS_WIDTH;
   localparam int NW = prsu_pkg::RES_CNT_WIDTH;

   // Config registers
   logic [BW-1:0]          sample_bits_ff, sample_bits_in;
   logic [COUNT_WIDTH-1:0] spc_ff, spc_in;

   // Strip state
   logic [prsu_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic [HW-1:0]                  held_ff, held_in;
   logic [COUNT_WIDTH-1:0]         done_ff, done_in;
   logic [prsu_pkg::BYTE_BITS-1:0] low_ff, low_in;
   logic                           phase_ff, phase_in;

   logic                           accept;
   logic [BW-1:0]                  eff_bits;
   logic                           pair_mode;
   logic                           active;
   logic [COUNT_WIDTH-1:0]         remain;
   logic [HW:0]                    held_sum;
   logic [HW-1:0]                  held_fill;
   logic [prsu_pkg::ACC_BITS-1:0]  acc_shift;
   logic [NW-1:0]                  bit_count;
   logic [7:0]                     used_bits;
   logic [NW-1:0]                  take;
   logic [COUNT_WIDTH-1:0]         done_step;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;

   // Config writes
   always_comb begin
      sample_bits_in = sample_bits_ff;
      spc_in         = spc_ff;
      if (csr.we) begin
         if (csr.index == prsu_pkg::REG_SAMPLE_BITS) begin
            sample_bits_in = csr.wdata[BW-1:0];
         end else begin
            spc_in = COUNT_WIDTH'(csr.wdata);
         end
      end
   end

   // Effective width: zero acts as one, above sixteen acts as sixteen
   always_comb begin
      if (sample_bits_ff == '0) begin
         eff_bits = BW'(1);
      end else if (sample_bits_ff > BW'(prsu_pkg::PAIR_BITS)) begin
         eff_bits = BW'(prsu_pkg::PAIR_BITS);
      end else begin
         eff_bits = sample_bits_ff;
      end
   end

   assign pair_mode = (eff_bits == BW'(prsu_pkg::PAIR_BITS));
   assign active    = (done_ff < spc_ff);
   assign remain    = spc_ff - done_ff;

   // Accumulator after shifting in the byte, bit count saturating at the accumulator size
   assign acc_shift = {acc_ff[prsu_pkg::ACC_BITS-prsu_pkg::BYTE_BITS-1:0], req_payload.data_byte};
   assign held_sum  = {1'b0, held_ff} + (HW+1)'(prsu_pkg::BYTE_BITS);
   assign held_fill = (held_sum > (HW+1)'(prsu_pkg::ACC_BITS)) ? HW'(prsu_pkg::ACC_BITS)
                                                               : held_sum[HW-1:0];

   // Samples available: count of i in 1..8 with i*bits <= held and i <= remaining
   always_comb begin
      bit_count = '0;
      for (int i = 1; i <= prsu_pkg::MAX_RESULTS; i++) begin
         if ((8'(i) * {3'b000, eff_bits} <= {3'b000, held_fill}) &&
             (remain >= COUNT_WIDTH'(i))) begin
            bit_count = bit_count + NW'(1);
         end
      end
   end

   assign used_bits = 8'(bit_count) * {3'b000, eff_bits};

   // Next state and job
   always_comb begin
      acc_in    = acc_ff;
      held_in   = held_ff;
      low_in    = low_ff;
      phase_in  = phase_ff;
      take      = '0;
      job       = '0;
      job.bits  = eff_bits;

      if (accept && active) begin
         if (pair_mode) begin
            if (!phase_ff) begin
               low_in   = req_payload.data_byte;
               phase_in = 1'b1;
            end else begin
               take     = NW'(1);
               phase_in = 1'b0;
               job.acc  = {8'h00, req_payload.data_byte, low_ff};
               job.pos  = HW'(prsu_pkg::PAIR_BITS);
            end
         end else begin
            take    = bit_count;
            acc_in  = acc_shift;
            held_in = HW'({3'b000, held_fill} - used_bits);
            job.acc = acc_shift;
            job.pos = held_fill;
         end
      end

      done_step     = done_ff + COUNT_WIDTH'(take);
      done_in       = accept ? done_step : done_ff;
      job.count     = take;
      job.strip_end = req_payload.strip_end;
      job.status    = prsu_pkg::STATUS_CONTINUE;

      // Strip end: report status, then clear all strip state
      if (accept && req_payload.strip_end) begin
         job.status = (done_step >= spc_ff) ? prsu_pkg::STATUS_COMPLETE
                                            : prsu_pkg::STATUS_SHORT;
         acc_in   = '0;
         held_in  = '0;
         done_in  = '0;
         low_in   = '0;
         phase_in = 1'b0;
      end
   end

   assign push = accept && ((take != '0) || req_payload.strip_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bits_ff <= prsu_pkg::SAMPLE_BITS_RESET;
         spc_ff         <= '0;
         acc_ff         <= '0;
         held_ff        <= '0;
         done_ff        <= '0;
         low_ff         <= '0;
         phase_ff       <= 1'b0;
      end else begin
         sample_bits_ff <= sample_bits_in;
         spc_ff         <= spc_in;
         acc_ff         <= acc_in;
         held_ff        <= held_in;
         done_ff        <= done_in;
         low_ff         <= low_in;
         phase_ff       <= phase_in;
      end
   end

   // Checks
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(prsu_pkg::ACC_BITS))
      else $error("bits held exceeds accumulator size");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.strip_end && !csr.we) |=>
         (done_ff == '0 && held_ff == '0 && !phase_ff))
      else $error("strip state not cleared after strip end");

   a_no_overcount: assert property (@(posedge clock) disable iff (reset)
      (push && job.count != '0) |-> (done_step <= spc_ff))
      else $error("samples taken beyond configured count");

endmodule

`default_nettype wire

// ----- src/prsu_fifo.sv -----
// Short job queue that decouples the front end from the result sequencer.
`default_nettype none

module prsu_fifo (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  prsu_pkg::job_type  push_data,
   input  wire                pop,
   output prsu_pkg::job_type  head,
   output logic               head_valid,
   output logic               full
);

   localparam int DEPTH = prsu_pkg::FIFO_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   prsu_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/prsu_back.sv -----
// Back end: walks each job and emits one result per cycle into the output register while it is not stalled.
`default_nettype none

module prsu_back (
   input  wire                       clock,
   input  wire                       reset,
   input  prsu_pkg::job_type         head,
   input  wire                       head_valid,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output prsu_pkg::rsp_payload_type rsp_payload
);

   localparam int HW = prsu_pkg::HELD_WIDTH;
   localparam int NW = prsu_pkg::RES_CNT_WIDTH;

   logic [NW-1:0]                       idx_ff, idx_in;
   logic [HW-1:0]                       pos_ff, pos_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   prsu_pkg::rsp_payload_type           rsp_ff, rsp_in;

   logic [NW-1:0]                       total;
   logic                                last;
   logic                                has_sample;
   logic [HW-1:0]                       pos_cur;
   logic [HW-1:0]                       shift;
   logic [prsu_pkg::ACC_BITS-1:0]       shifted;
   logic                                emit;

   // A job with no samples still yields one result (strip end marker)
   assign total      = (head.count == '0) ? NW'(1) : head.count;
   assign last       = (idx_ff == total - NW'(1));
   assign has_sample = (head.count != '0);
   assign pos_cur    = (idx_ff == '0) ? head.pos : pos_ff;
   assign shift      = pos_cur - head.bits;
   assign shifted    = head.acc >> shift;

   assign emit = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = emit && last;

   // Result formation
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_stall ? rsp_valid_ff : 1'b0;
      idx_in             = idx_ff;
      pos_in             = pos_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.sample      = has_sample ?
            (shifted[prsu_pkg::SAMPLE_WIDTH-1:0] & prsu_pkg::sample_mask(head.bits)) : '0;
         rsp_in.has_sample  = has_sample;
         rsp_in.last_of_run = last;
         rsp_in.end_status  = (last && head.strip_end) ? head.status
                                                       : prsu_pkg::STATUS_CONTINUE;
         idx_in             = last ? '0 : idx_ff + NW'(1);
         pos_in             = shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- src/packed_raw_sample_unpacker.sv -----
// Top level of the packed raw sample unpacker: front end, job queue and result sequencer.
// A result is registered: the transfer edge writes its job into the queue, and the output
// register is loaded from the queue head. Throughput: one byte per cycle while each byte
// yields at most one result; a byte that yields k samples holds the sequencer while it emits
// all k, and the input stalls only while the four-entry queue is full. Reset (synchronous,
// active high) sets sample_bits to 16, samples_per_strip to 0, clears state, empties the queue.
`default_nettype none

module packed_raw_sample_unpacker #(
   parameter int COUNT_WIDTH = prsu_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      csr_we,
   input  wire  [prsu_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  wire  [prsu_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  prsu_pkg::req_payload_type                req_payload,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output prsu_pkg::rsp_payload_type                rsp_payload
);

   prsu_pkg::csr_write_type csr;
   prsu_pkg::job_type       push_job;
   prsu_pkg::job_type       head;
   logic                    push;
   logic                    pop;
   logic                    head_valid;
   logic                    fifo_full;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   prsu_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .fifo_full   (fifo_full),
      .push        (push),
      .job         (push_job)
   );

   prsu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_job),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (fifo_full)
   );

   prsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- verif/packed_raw_sample_unpacker_tb.sv -----
// Self-checking testbench for the packed raw sample unpacker: directed and random strips.
`timescale 1ns / 1ps

module packed_raw_sample_unpacker_tb;
   import prsu_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 420;
   localparam int CALM_AFTER    = 360;
   localparam int SHORT_COUNT   = 64;
   localparam int HOLD_BYTES    = 16;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_we      = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]   csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata   = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   rsp_payload_type            rsp_payload;

   // Local copy of the block's registers and strip state
   logic [BITS_WIDTH-1:0]          cfg_bits   = SAMPLE_BITS_RESET;
   logic [COUNT_WIDTH_DEFAULT-1:0] cfg_count  = '0;
   logic [ACC_BITS-1:0]            acc_bits   = '0;
   int                             acc_held   = 0;
   logic [COUNT_WIDTH_DEFAULT-1:0] strip_done = '0;
   logic [BYTE_BITS-1:0]           low_half   = '0;
   logic                           have_low   = 1'b0;

   req_payload_type bytes_to_send [$];
   rsp_payload_type samples_due [$];
   rsp_payload_type due_head;

   int   bytes_queued   = 0;
   int   bytes_taken    = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   recv_gap       = 0;
   int   hold_count     = 0;
   logic calm           = 1'b0;
   logic long_hold_req  = 1'b0;
   wire  long_hold_on   = long_hold_req && (hold_count < LONG_HOLD);

   packed_raw_sample_unpacker u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the samples one accepted byte produces and queue them as due
   task automatic unpack_byte(input req_payload_type in_byte);
      rsp_payload_type         outs [MAX_RESULTS];
      int                      width;
      int                      n;
      logic [SAMPLE_WIDTH-1:0] mask;
      foreach (outs[i]) outs[i] = '0;
      n = 0;
      width = int'(cfg_bits);
      if (width == 0) width = 1;
      if (width > PAIR_BITS) width = PAIR_BITS;
      mask = SAMPLE_WIDTH'((32'd1 << width) - 32'd1);
      if (strip_done < cfg_count) begin
         if (width == PAIR_BITS) begin
            // little-endian pair: first byte is the low half
            if (!have_low) begin
               low_half = in_byte.data_byte;
               have_low = 1'b1;
            end else begin
               outs[n].sample     = {in_byte.data_byte, low_half};
               outs[n].has_sample = 1'b1;
               n++;
               strip_done++;
               have_low = 1'b0;
            end
         end else begin
            // MSB-first accumulator, held count saturates at the accumulator size
            acc_bits = {acc_bits[ACC_BITS-BYTE_BITS-1:0], in_byte.data_byte};
            acc_held = (acc_held + BYTE_BITS > ACC_BITS) ? ACC_BITS : acc_held + BYTE_BITS;
            while (acc_held >= width && strip_done < cfg_count && n < MAX_RESULTS) begin
               acc_held -= width;
               outs[n].sample     = SAMPLE_WIDTH'(acc_bits >> acc_held) & mask;
               outs[n].has_sample = 1'b1;
               n++;
               strip_done++;
            end
         end
      end
      if (in_byte.strip_end) begin
         // end byte always reports, even with no sample
         if (n == 0) n = 1;
         outs[n-1].end_status = (strip_done >= cfg_count) ? STATUS_COMPLETE : STATUS_SHORT;
         acc_bits   = '0;
         acc_held   = 0;
         strip_done = '0;
         low_half   = '0;
         have_low   = 1'b0;
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) samples_due.insert(samples_due.size(), outs[i]);
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic queue_byte(input logic [BYTE_BITS-1:0] value, input logic last);
      req_payload_type item;
      item.data_byte = value;
      item.strip_end = last;
      bytes_to_send.insert(bytes_to_send.size(), item);
      bytes_queued++;
   endtask

   // Block until every queued byte is taken and every due sample has arrived
   task automatic wait_for_idle();
      do
         @(posedge clock);
      while (bytes_taken != bytes_queued || samples_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      wait_for_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_SAMPLE_BITS) cfg_bits = value[BITS_WIDTH-1:0];
      else cfg_count = value[COUNT_WIDTH_DEFAULT-1:0];
   endtask

   // Input driver: offers queued bytes, with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            unpack_byte(req_payload);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap  <= $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               req_payload <= bytes_to_send.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long receiver hold-off, counted here
   always @(posedge clock) begin
      if (long_hold_on) hold_count <= hold_count + 1;
   end

   // Result side stall: long hold-off or random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else if (long_hold_on) begin
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         recv_gap  <= $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result monitor: each transfer against the oldest due sample
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (samples_due.size() == 0) begin
            flag_mismatch("unexpected transfer", int'(rsp_payload), 0);
         end else begin
            due_head = samples_due.pop_front();
            if (rsp_payload.sample !== due_head.sample)
               flag_mismatch("sample", int'(rsp_payload.sample), int'(due_head.sample));
            if (rsp_payload.has_sample !== due_head.has_sample)
               flag_mismatch("has_sample", int'(rsp_payload.has_sample),
                             int'(due_head.has_sample));
            if (rsp_payload.last_of_run !== due_head.last_of_run)
               flag_mismatch("last_of_run", int'(rsp_payload.last_of_run),
                             int'(due_head.last_of_run));
            if (rsp_payload.end_status !== due_head.end_status)
               flag_mismatch("end_status", int'(rsp_payload.end_status),
                             int'(due_head.end_status));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                        strips;
      int                        len;
      int                        width;
      int                        need;
      int                        generated;
      logic [CSR_DATA_WIDTH-1:0] wdata;
      logic [BITS_WIDTH-1:0]     bits_val;
      logic                      noisy;
      logic                      leave_open;
      generated = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero count, so bytes are dropped and the end reports complete
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);

      // Pair mode, extremes, count reached then dropped bytes
      write_csr(REG_SAMPLE_BITS, 28'd16);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd2);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b1);
      // short strip with a sample on the end byte
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b1);
      // odd trailing byte dropped at strip end
      queue_byte(8'h77, 1'b1);

      // One-bit samples: eight per byte, the cap
      write_csr(REG_SAMPLE_BITS, 28'd1);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd20);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'hFF, 1'b1);

      // Width zero with junk in upper bits, maximum count, strip left open
      write_csr(REG_SAMPLE_BITS, 28'hFFFFFE0);
      write_csr(REG_SAMPLES_PER_STRIP, 28'hFFFFFFF);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b0);

      // Width above sixteen acts as pair mode, reading the open strip
      write_csr(REG_SAMPLE_BITS, 28'h000001F);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);

      // Count lowered below samples already taken
      write_csr(REG_SAMPLES_PER_STRIP, 28'd1);
      queue_byte(8'hC3, 1'b1);

      // Raise the count one at a time so the accumulator overfills
      write_csr(REG_SAMPLE_BITS, 28'd1);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd1);
      queue_byte(8'h5A, 1'b0);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd2);
      queue_byte(8'hC3, 1'b0);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd3);
      queue_byte(8'h96, 1'b0);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd4);
      queue_byte(8'h3C, 1'b0);
      write_csr(REG_SAMPLE_BITS, 28'd5);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd100);
      queue_byte(8'hE7, 1'b1);

      // Receiver holds off while the sender keeps offering, so the queue fills and stalls
      write_csr(REG_SAMPLE_BITS, 28'd8);
      write_csr(REG_SAMPLES_PER_STRIP, 28'd16);
      long_hold_req <= 1'b1;
      for (int i = 0; i < HOLD_BYTES; i++)
         queue_byte(BYTE_BITS'($urandom()), i == HOLD_BYTES - 1);
      wait_for_idle();

      // Random phases: new settings, then mostly well-sized strips
      while (generated < RANDOM_ITEMS) begin
         if (generated >= CALM_AFTER) calm <= 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       bits_val = '0;
               1:       bits_val = BITS_WIDTH'(1);
               2:       bits_val = BITS_WIDTH'(PAIR_BITS);
               3:       bits_val = BITS_WIDTH'($urandom_range(17, 31));
               default: bits_val = BITS_WIDTH'($urandom_range(2, 15));
            endcase
            wdata = CSR_DATA_WIDTH'($urandom());
            wdata[BITS_WIDTH-1:0] = bits_val;
            write_csr(REG_SAMPLE_BITS, wdata);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       wdata = '0;
               1:       wdata = '1;
               2:       wdata = CSR_DATA_WIDTH'(1);
               default: wdata = CSR_DATA_WIDTH'($urandom_range(2, 24));
            endcase
            write_csr(REG_SAMPLES_PER_STRIP, wdata);
         end

         width = int'(cfg_bits);
         if (width == 0) width = 1;
         if (width > PAIR_BITS) width = PAIR_BITS;
         strips = $urandom_range(1, 3);
         for (int s = 0; s < strips; s++) begin
            noisy      = ($urandom_range(0, 4) == 0);
            leave_open = (s == strips - 1) && ($urandom_range(0, 3) == 0);
            if (cfg_count == 0 || cfg_count > SHORT_COUNT) begin
               len = $urandom_range(1, 12);
            end else begin
               need = (width == PAIR_BITS) ? 2 * int'(cfg_count)
                                           : (int'(cfg_count) * width + 7) / 8;
               len = need + $urandom_range(0, 2);
               if (len > 1 && $urandom_range(0, 3) == 0) len--;
            end
            for (int i = 0; i < len; i++) begin
               if (noisy) queue_byte(BYTE_BITS'($urandom()), $urandom_range(0, 5) == 0);
               else queue_byte(BYTE_BITS'($urandom()), (i == len - 1) && !leave_open);
               generated++;
            end
         end
         // sender sometimes pauses until all due samples are back
         if ($urandom_range(0, 3) == 0) wait_for_idle();
      end

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
